// File: sv/tlc_pkg.sv
// tlc_pkg: shared types, constants and the arctangent table of the trajectory limit checker
`default_nettype none
package tlc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;
  localparam int X_W          = 28;
  localparam int ACC_W        = 21;
  localparam int HEAD_W       = 17;
  localparam int MAG_W        = 17;
  localparam int SPROD_W      = 30;
  localparam int STEER_W      = 22;
  localparam int DS_W         = 23;
  localparam int MPROD_W      = 44;
  localparam int RHS_W        = 48;
  localparam int LV_W         = 37;
  localparam int LS_W         = 43;
  localparam int ADDR_W       = 5;

  localparam logic signed [ACC_W-1:0] PI_Q16   = ACC_W'(205887);
  localparam logic [15:0]             GAIN_Q16 = 16'd39797;
  localparam logic [19:0]             US_PER_S = 20'd1000000;
  localparam logic [MAG_W-1:0]        MAG_MAX  = {MAG_W{1'b1}};

  localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [2:0] REG_ACCEL_LIMIT = 3'd1;
  localparam logic [2:0] REG_DECEL_LIMIT = 3'd2;
  localparam logic [2:0] REG_STEER_LIMIT = 3'd3;
  localparam logic [2:0] REG_STEER_RATE  = 3'd4;
  localparam logic [2:0] REG_WHEEL_BASE  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_MAG, ST_STEER, ST_DIFF, ST_PREP, ST_MUL, ST_CMP, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] speed_limit;
    logic [15:0] accel_limit;
    logic [15:0] decel_limit;
    logic [15:0] steer_limit;
    logic [15:0] steer_rate_limit;
    logic [11:0] wheel_base;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              mag;
    logic              steer;
    logic              diff;
    logic              prep;
    logic              mul;
    logic              cmp;
    logic              clear;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic feasible;
  } status_t;

  function automatic logic signed [ACC_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = ACC_W'(51472);
      5'd1:    v = ACC_W'(30386);
      5'd2:    v = ACC_W'(16055);
      5'd3:    v = ACC_W'(8150);
      5'd4:    v = ACC_W'(4091);
      5'd5:    v = ACC_W'(2047);
      5'd6:    v = ACC_W'(1024);
      5'd7:    v = ACC_W'(512);
      5'd8:    v = ACC_W'(256);
      5'd9:    v = ACC_W'(128);
      5'd10:   v = ACC_W'(64);
      5'd11:   v = ACC_W'(32);
      5'd12:   v = ACC_W'(16);
      5'd13:   v = ACC_W'(8);
      5'd14:   v = ACC_W'(4);
      5'd15:   v = ACC_W'(2);
      5'd16:   v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/tlc_regs.sv
// tlc_regs: configuration register file behind the apb-style port
`default_nettype none
module tlc_regs (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire [tlc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire [31:0]                 cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output tlc_pkg::cfg_t              cfg
);
  import tlc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SPEED_LIMIT: cfg_nxt.speed_limit      = cfg_pwdata[15:0];
        REG_ACCEL_LIMIT: cfg_nxt.accel_limit      = cfg_pwdata[15:0];
        REG_DECEL_LIMIT: cfg_nxt.decel_limit      = cfg_pwdata[15:0];
        REG_STEER_LIMIT: cfg_nxt.steer_limit      = cfg_pwdata[15:0];
        REG_STEER_RATE:  cfg_nxt.steer_rate_limit = cfg_pwdata[15:0];
        REG_WHEEL_BASE:  cfg_nxt.wheel_base       = cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEED_LIMIT: cfg_prdata = {16'd0, cfg_r.speed_limit};
      REG_ACCEL_LIMIT: cfg_prdata = {16'd0, cfg_r.accel_limit};
      REG_DECEL_LIMIT: cfg_prdata = {16'd0, cfg_r.decel_limit};
      REG_STEER_LIMIT: cfg_prdata = {16'd0, cfg_r.steer_limit};
      REG_STEER_RATE:  cfg_prdata = {16'd0, cfg_r.steer_rate_limit};
      REG_WHEEL_BASE:  cfg_prdata = {20'd0, cfg_r.wheel_base};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit      <= 16'hFFFF;
      cfg_r.accel_limit      <= 16'hFFFF;
      cfg_r.decel_limit      <= 16'hFFFF;
      cfg_r.steer_limit      <= 16'hFFFF;
      cfg_r.steer_rate_limit <= 16'hFFFF;
      cfg_r.wheel_base       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/tlc_ctrl.sv
// tlc_ctrl: sequencer that steps one point through cordic, scaling and limit checks
`default_nettype none
module tlc_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_last_point,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_feasible,
  output tlc_pkg::cmd_t      cmd,
  input  tlc_pkg::status_t   status
);
  import tlc_pkg::*;

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_feasible_r, out_feasible_nxt;
  logic              accept;

  assign in_ready     = (state_r == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_feasible = out_feasible_r;

  always_comb begin
    state_nxt        = state_r;
    iter_nxt         = iter_r;
    last_nxt         = last_r;
    out_valid_nxt    = out_valid_r;
    out_feasible_nxt = out_feasible_r;
    cmd              = '0;
    cmd.iter         = iter_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last_point;
          iter_nxt  = '0;
          state_nxt = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        cmd.step = 1'b1;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = ST_STEER;
      end
      ST_STEER: begin
        cmd.steer = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_feasible_nxt = status.feasible;
          cmd.clear        = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_feasible_r <= out_feasible_nxt;
  end

endmodule
`default_nettype wire

// File: sv/tlc_dp.sv
// tlc_dp: cordic vectoring datapath, steering scaling and trajectory limit checks
`default_nettype none
module tlc_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  wire signed [15:0]  in_long_speed,
  input  wire signed [15:0]  in_lat_speed,
  input  wire        [31:0]  in_time_us,
  input  tlc_pkg::cfg_t      cfg,
  input  tlc_pkg::cmd_t      cmd,
  output tlc_pkg::status_t   status
);
  import tlc_pkg::*;

  logic signed [X_W-1:0]     x_r, y_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      zero_r;
  logic [31:0]               time_r;
  logic [MPROD_W-1:0]        prod_r;
  logic signed [HEAD_W-1:0]  head_r;
  logic [MAG_W-1:0]          mag_r;
  logic signed [SPROD_W-1:0] sprod_r;
  logic signed [STEER_W-1:0] steer_r;
  logic [MAG_W-1:0]          absdv_r;
  logic                      dvneg_r;
  logic [31:0]               dt_r;
  logic                      dtpos_r;
  logic [DS_W-1:0]           absds_r;
  logic                      ptviol_r;
  logic [LV_W-1:0]           lv_r;
  logic [LS_W-1:0]           ls_r;
  logic [RHS_W-1:0]          ra_r, rd_r, rs_r;
  logic                      violated_r;
  logic                      have_prev_r;
  logic [MAG_W-1:0]          prev_mag_r;
  logic signed [STEER_W-1:0] prev_steer_r;
  logic [31:0]               prev_time_r;

  // load and step
  logic signed [16:0]        lx, ly;
  logic                      xneg;
  logic signed [X_W-1:0]     xs, ys;
  logic signed [ACC_W-1:0]   at;
  // later stages
  logic [X_W-1:0]            xpos;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic [MPROD_W-1:0]        mag_rnd;
  logic signed [SPROD_W-1:0] sprod_rnd;
  logic signed [MAG_W:0]     dv;
  logic signed [DS_W-1:0]    ds;
  logic [STEER_W-1:0]        abs_steer;

  assign status.feasible = !violated_r;

  always_comb begin
    lx      = 17'(in_long_speed);
    ly      = 17'(in_lat_speed);
    xneg    = in_long_speed[15];
    xs      = x_r >>> cmd.iter;
    ys      = y_r >>> cmd.iter;
    at      = atan_q16(ATAN_IDX_W'(cmd.iter));
    xpos    = x_r[X_W-1] ? '0 : x_r;
    acc_rnd = acc_r + ACC_W'(8);
    mag_rnd = prod_r + MPROD_W'(1 << 23);
    sprod_rnd = sprod_r + SPROD_W'(128);
    dv      = $signed({1'b0, mag_r}) - $signed({1'b0, prev_mag_r});
    ds      = DS_W'(steer_r) - DS_W'(prev_steer_r);
    abs_steer = steer_r[STEER_W-1] ? STEER_W'(-steer_r) : STEER_W'(steer_r);
  end

  // trajectory state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      violated_r   <= 1'b0;
      have_prev_r  <= 1'b0;
      prev_mag_r   <= '0;
      prev_steer_r <= '0;
      prev_time_r  <= '0;
    end else if (cmd.clear) begin
      violated_r   <= 1'b0;
      have_prev_r  <= 1'b0;
      prev_mag_r   <= '0;
      prev_steer_r <= '0;
      prev_time_r  <= '0;
    end else if (cmd.cmp) begin
      violated_r   <= violated_r || ptviol_r ||
                      (dtpos_r && !dvneg_r && ({11'd0, lv_r} > ra_r)) ||
                      (dtpos_r && dvneg_r && ({11'd0, lv_r} > rd_r)) ||
                      (dtpos_r && ({5'd0, ls_r} > rs_r));
      have_prev_r  <= 1'b1;
      prev_mag_r   <= mag_r;
      prev_steer_r <= steer_r;
      prev_time_r  <= time_r;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= {X_W'(xneg ? -lx : lx)} <<< 8;
      y_r    <= {X_W'(xneg ? -ly : ly)} <<< 8;
      acc_r  <= xneg ? (in_lat_speed[15] ? -PI_Q16 : PI_Q16) : '0;
      zero_r <= (in_long_speed == 16'sd0) && (in_lat_speed == 16'sd0);
      time_r <= in_time_us;
    end else if (cmd.step) begin
      if (!y_r[X_W-1]) begin
        x_r   <= x_r + ys;
        y_r   <= y_r - xs;
        acc_r <= acc_r + at;
      end else begin
        x_r   <= x_r - ys;
        y_r   <= y_r + xs;
        acc_r <= acc_r - at;
      end
    end
    if (cmd.mag) begin
      prod_r <= MPROD_W'(xpos) * MPROD_W'(GAIN_Q16);
      head_r <= zero_r ? '0 : HEAD_W'(acc_rnd >>> 4);
    end
    if (cmd.steer) begin
      mag_r   <= (mag_rnd[MPROD_W-1:24] > MPROD_W'(MAG_MAX)) ? MAG_MAX
                 : mag_rnd[24 +: MAG_W];
      sprod_r <= SPROD_W'(head_r) * $signed(SPROD_W'({1'b0, cfg.wheel_base}));
    end
    if (cmd.diff) begin
      steer_r <= STEER_W'(sprod_rnd >>> 8);
      dvneg_r <= dv[MAG_W];
      absdv_r <= dv[MAG_W] ? MAG_W'(-dv) : MAG_W'(dv);
      dt_r    <= time_r - prev_time_r;
      dtpos_r <= have_prev_r && (time_r > prev_time_r);
    end
    if (cmd.prep) begin
      absds_r  <= ds[DS_W-1] ? DS_W'(-ds) : DS_W'(ds);
      ptviol_r <= (mag_r > MAG_W'(cfg.speed_limit)) ||
                  (abs_steer > STEER_W'(cfg.steer_limit));
    end
    if (cmd.mul) begin
      lv_r <= LV_W'(absdv_r) * LV_W'(US_PER_S);
      ls_r <= LS_W'(absds_r) * LS_W'(US_PER_S);
      ra_r <= RHS_W'(cfg.accel_limit) * RHS_W'(dt_r);
      rd_r <= RHS_W'(cfg.decel_limit) * RHS_W'(dt_r);
      rs_r <= RHS_W'(cfg.steer_rate_limit) * RHS_W'(dt_r);
    end
  end

endmodule
`default_nettype wire

// File: sv/trajectory_limit_checker_core.sv
// trajectory_limit_checker_core: top level of the trajectory feasibility checker
// sequence: a point is taken in idle, then runs the cordic iterations and the magnitude,
// steering, difference, preparation, multiply and compare states; a last point then emits
// points: a new point is taken only back in idle, and a last point also waits in emit while
// an older verdict still waits; one shared cordic iteration unit serves every point
// reset: synchronous active-low rst_n clears the sequencer, the output slot and the
// trajectory state; registers return to their documented defaults
`default_nettype none
module trajectory_limit_checker_core (
  input  wire                        clk,
  input  wire                        rst_n,
  // point requests
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire signed [15:0]          in_long_speed,
  input  wire signed [15:0]          in_lat_speed,
  input  wire        [31:0]          in_time_us,
  input  wire                        in_last_point,
  // verdict requests
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       out_feasible,
  // configuration
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire [tlc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire [31:0]                 cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import tlc_pkg::*;

  cfg_t    cfg;    // live limits and wheel base
  cmd_t    cmd;    // per-cycle datapath commands from the sequencer
  status_t status; // running verdict back to the sequencer

  // register file: the user must write it only while no point is in flight; not enforced here
  tlc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer: accepts a request in idle, holds the verdict in its own output register;
  // a waiting verdict holds up the next point only once a newer last point must emit
  tlc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_last_point (in_last_point),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_feasible  (out_feasible),
    .cmd           (cmd),
    .status        (status)
  );

  // datapath: cordic magnitude and heading, steering scaling, pair checks by
  // cross-multiplication instead of division
  tlc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_long_speed (in_long_speed),
    .in_lat_speed  (in_lat_speed),
    .in_time_us    (in_time_us),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
`default_nettype wire

// File: sv/tlc_checker.sv
// tlc_checker: port-level assertions for the trajectory limit checker and their bind
`default_nettype none
module tlc_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_feasible,
  input wire cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_feasible))
    else $error("verdict dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new point taken while one is in flight");

  a_no_instant_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("verdict appeared right after a point was taken");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port stalled");

endmodule

bind trajectory_limit_checker_core tlc_checker u_tlc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_feasible (out_feasible),
  .cfg_pready   (cfg_pready)
);
`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench of the trajectory limit checker core
`default_nettype none
module tb;
  import tlc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct {
    logic signed [15:0] long_speed;
    logic signed [15:0] lat_speed;
    logic [31:0]        time_us;
    logic               last_point;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_long_speed = '0;
  logic signed [15:0] in_lat_speed = '0;
  logic [31:0]        in_time_us = '0;
  logic               in_last_point = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_feasible;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]  cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  trajectory_limit_checker_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copies of the limits and trajectory state
  int unsigned lim_speed, lim_accel, lim_decel, lim_steer, lim_rate, wb;
  int unsigned last_mag;
  longint      last_steer;
  logic [31:0] last_time;
  bit          seen_prev, any_violation;

  point_t pending_points[$];
  bit     feasible_q[$];
  int     errors = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     watchdog = 0;
  bit     hold_off = 0;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // cordic vectoring: speed magnitude and heading in 1/4096 rad
  function automatic void cordic_vec(longint vx, longint vy,
                                     output int unsigned mag, output longint head);
    longint x, y, acc, xs, ys;
    longint m;
    longint atan_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1};
    x = vx; y = vy; acc = 0;
    if (x == 0 && y == 0) begin
      mag = 0; head = 0;
      return;
    end
    if (x < 0) begin
      acc = (y >= 0) ? 205887 : -205887;
      x = -x; y = -y;
    end
    x = x * 256; y = y * 256;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc += (i < 17) ? atan_tab[i] : 0;
      end else begin
        x = x - ys; y = y + xs; acc -= (i < 17) ? atan_tab[i] : 0;
      end
    end
    if (x < 0) x = 0;
    m = (x * 39797 + (64'd1 << 23)) >>> 24;
    if (m > 131071) m = 131071;
    mag = int'(m);
    head = fshr(acc + 8, 4);
  endfunction

  // judge one point, pushing a verdict on the last point
  function automatic void judge_point(point_t p);
    int unsigned mag;
    longint head, steer, abs_steer, dt, dv, ds;
    cordic_vec(p.long_speed, p.lat_speed, mag, head);
    steer = fshr(head * longint'(wb) + 128, 8);
    abs_steer = steer < 0 ? -steer : steer;
    if (mag > lim_speed) any_violation = 1;
    if (abs_steer > longint'(lim_steer)) any_violation = 1;
    if (seen_prev) begin
      dt = longint'(p.time_us) - longint'(last_time);
      if (dt > 0) begin
        dv = longint'(mag) - longint'(last_mag);
        ds = steer - last_steer;
        if (ds < 0) ds = -ds;
        if (dv * 1000000 > longint'(lim_accel) * dt) any_violation = 1;
        if (-dv * 1000000 > longint'(lim_decel) * dt) any_violation = 1;
        if (ds * 1000000 > longint'(lim_rate) * dt) any_violation = 1;
      end
    end
    last_mag = mag; last_steer = steer; last_time = p.time_us; seen_prev = 1;
    if (p.last_point) begin
      feasible_q.push_back(!any_violation);
      last_mag = 0; last_steer = 0; last_time = 0; seen_prev = 0; any_violation = 0;
    end
  endfunction

  // driver: request from the pending queue, random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        judge_point(pending_points.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold the request until it is accepted
      end else if (pending_points.size() > 0 && !hold_off
                   && $urandom_range(99) >= idle_pct) begin
        in_valid      <= 1'b1;
        in_long_speed <= pending_points[0].long_speed;
        in_lat_speed  <= pending_points[0].lat_speed;
        in_time_us    <= pending_points[0].time_us;
        in_last_point <= pending_points[0].last_point;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each verdict with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (feasible_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected verdict feasible=%0b", out_feasible);
        end else begin
          if (out_feasible !== feasible_q[0]) begin
            errors++;
            if (errors <= 10)
              $display("verdict mismatch: expected %0b actual %0b", feasible_q[0], out_feasible);
          end
          void'(feasible_q.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        watchdog <= 0;
      end else begin
        watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, int unsigned val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_SPEED_LIMIT: lim_speed = val & 16'hFFFF;
      REG_ACCEL_LIMIT: lim_accel = val & 16'hFFFF;
      REG_DECEL_LIMIT: lim_decel = val & 16'hFFFF;
      REG_STEER_LIMIT: lim_steer = val & 16'hFFFF;
      REG_STEER_RATE:  lim_rate  = val & 16'hFFFF;
      REG_WHEEL_BASE:  wb        = val & 12'hFFF;
      default: ;
    endcase
  endtask

  // wait for every queued point and verdict, then let the block settle
  task automatic drain();
    while (pending_points.size() > 0 || in_valid || feasible_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_speed();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // one trajectory of random points, mostly smooth and increasing in time
  task automatic queue_trajectory(int npts);
    point_t p;
    logic [31:0] t;
    logic signed [15:0] vx, vy;
    t = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1000);
    vx = rnd_speed(); vy = rnd_speed();
    for (int k = 0; k < npts; k++) begin
      if ($urandom_range(9) < 7) begin
        vx = vx + 16'($signed($urandom_range(0, 400)) - 200);
        vy = vy + 16'($signed($urandom_range(0, 200)) - 100);
        t = t + $urandom_range(0, 200000);
      end else begin
        vx = rnd_speed(); vy = rnd_speed();
        t = ($urandom_range(1) == 0) ? t - $urandom_range(0, 50000) : $urandom;
      end
      p.long_speed = vx; p.lat_speed = vy; p.time_us = t;
      p.last_point = (k == npts - 1);
      pending_points.push_back(p);
    end
  endtask

  function automatic point_t mk(int vx, int vy, logic [31:0] t, bit lst);
    point_t p;
    p.long_speed = 16'(vx); p.lat_speed = 16'(vy); p.time_us = t; p.last_point = lst;
    return p;
  endfunction

  initial begin
    int sent;
    lim_speed = 65535; lim_accel = 65535; lim_decel = 65535;
    lim_steer = 65535; lim_rate = 65535; wb = 0;
    last_mag = 0; last_steer = 0; last_time = 0; seen_prev = 0; any_violation = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset limits, zero velocity, extremes, non-positive time step
    pending_points.push_back(mk(0, 0, 0, 1));
    pending_points.push_back(mk(32767, 32767, 32'hFFFF_FFFF, 1));
    pending_points.push_back(mk(-32768, 0, 10, 0));
    pending_points.push_back(mk(-32768, -1, 10, 0));
    pending_points.push_back(mk(0, -32768, 5, 1));
    drain();
    cfg_write(REG_WHEEL_BASE, 2560);
    cfg_write(REG_SPEED_LIMIT, 1000);
    cfg_write(REG_ACCEL_LIMIT, 0);
    cfg_write(REG_DECEL_LIMIT, 500);
    cfg_write(REG_STEER_LIMIT, 3000);
    cfg_write(REG_STEER_RATE, 0);
    cfg_write(3'd7, 32'hFFFF_FFFF);
    pending_points.push_back(mk(500, 0, 0, 0));
    pending_points.push_back(mk(600, 0, 1000000, 0));
    pending_points.push_back(mk(600, 0, 1000000, 1));
    pending_points.push_back(mk(900, 100, 100, 0));
    pending_points.push_back(mk(400, 100, 2000000, 1));
    pending_points.push_back(mk(-200, 300, 0, 1));
    pending_points.push_back(mk(0, 200, 0, 0));
    pending_points.push_back(mk(0, 200, 32'hFFFF_FFFF, 1));
    pending_points.push_back(mk(1, 0, 0, 1));
    drain();

    // random phases over several register settings and idling profiles
    sent = 0;
    for (int ph = 0; sent < 1350; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      case (ph % 3)
        0: begin
          cfg_write(REG_SPEED_LIMIT, 65535); cfg_write(REG_ACCEL_LIMIT, 65535);
          cfg_write(REG_DECEL_LIMIT, 65535); cfg_write(REG_STEER_LIMIT, 65535);
          cfg_write(REG_STEER_RATE, 65535);  cfg_write(REG_WHEEL_BASE, 0);
        end
        1: begin
          cfg_write(REG_SPEED_LIMIT, 0);  cfg_write(REG_ACCEL_LIMIT, 0);
          cfg_write(REG_DECEL_LIMIT, 0);  cfg_write(REG_STEER_LIMIT, 0);
          cfg_write(REG_STEER_RATE, 0);   cfg_write(REG_WHEEL_BASE, 2560);
        end
        default: begin
          cfg_write(REG_SPEED_LIMIT, $urandom_range(20000, 65535));
          cfg_write(REG_ACCEL_LIMIT, $urandom);
          cfg_write(REG_DECEL_LIMIT, $urandom);
          cfg_write(REG_STEER_LIMIT, $urandom_range(2000, 65535));
          cfg_write(REG_STEER_RATE, $urandom);
          cfg_write(REG_WHEEL_BASE, $urandom_range(0, 2560));
        end
      endcase
      for (int tr = 0; tr < 12; tr++) begin
        int n;
        n = $urandom_range(1, 18);
        queue_trajectory(n);
        sent += n;
      end
      // pause the sender once per phase until all verdicts are in
      while (pending_points.size() > 20) @(posedge clk);
      hold_off = 1;
      while (in_valid || feasible_q.size() > 0 || pending_points.size() == 0 && 0) @(posedge clk);
      while (in_valid) @(posedge clk);
      while (feasible_q.size() > 0 && pending_points.size() == 0) @(posedge clk);
      hold_off = 0;
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
